@@ rtl/core/gaussian_polar_sampler_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the gaussian polar sampler
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_POLAR_SAMPLER_ASSERT_SVH
`define GAUSSIAN_POLAR_SAMPLER_ASSERT_SVH

// Property checked at every edge.
`define GPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent this cycle, consequent on the next edge.
`define GPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/gps_pkg.sv @@
// ----------------------------------------------------------------------------
// gps_pkg
// Types, constants and the constant log2 helper for the polar sampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gps_pkg;

  localparam int UNIFORM_BITS     = 16;
  localparam int SAMPLE_FRAC_BITS = 12;
  // (c * L) keeps bits from this position on
  localparam int PROD_SHIFT       = 56 - 2 * SAMPLE_FRAC_BITS;

  localparam logic [UNIFORM_BITS-1:0] U_MAX = '1;
  // M^2, first rejected value of N
  localparam logic [32:0] M_SQ = 33'h0_FFFE_0001;
  // 2 ln 2 in Q.30
  localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;
  localparam logic [14:0] TRUNC_LIMIT_RST = 15'd12288;

  typedef enum logic [0:0] {
    REG_TRUNC_ENABLE = 1'b0,
    REG_TRUNC_LIMIT  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] sample;
    logic        second_of_pair;
    logic        last;
  } result_t;

  // log2 in Q.30 by repeated squaring of the Q1.31 mantissa
  function automatic logic [34:0] log2_q30_f(input logic [31:0] x);
    logic [4:0]  k;
    logic [63:0] m;
    logic [29:0] frac;
    k = '0;
    for (int b = 0; b < 32; b++) begin
      if (x[b]) k = 5'(b);
    end
    m    = {32'd0, x} << (5'd31 - k);
    frac = '0;
    for (int i = 29; i >= 0; i--) begin
      m = (m * m) >> 31;
      if (m[32]) begin
        m       = m >> 1;
        frac[i] = 1'b1;
      end
    end
    return {k, frac};
  endfunction

  // log2(M) in Q.30
  localparam logic [34:0] LOG2_M = log2_q30_f(32'(U_MAX));

endpackage

`default_nettype wire

@@ rtl/core/gps_log2_pipe.sv @@
// ----------------------------------------------------------------------------
// gps_log2_pipe
// log2 of a nonzero 32-bit word in Q.30: one normalize stage, then one
// squaring stage per fraction bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gps_log2_pipe
  import gps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        adv,
  input  wire logic [31:0] x,
  output logic      [34:0] y
);

  localparam int NBITS = 30;

  logic [4:0]  k_s [0:NBITS];
  logic [31:0] m_s [0:NBITS];
  logic [29:0] f_s [0:NBITS];

  logic [4:0]  nk;
  logic [31:0] nm;

  // leading one
  always_comb begin
    nk = '0;
    for (int b = 0; b < 32; b++) begin
      if (x[b]) nk = 5'(b);
    end
    nm = x << (5'd31 - nk);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k_s[0] <= nk;
      m_s[0] <= nm;
      f_s[0] <= '0;
    end
  end

  for (genvar j = 1; j <= NBITS; j++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] t;
    assign sq = {32'd0, m_s[j-1]} * {32'd0, m_s[j-1]};
    assign t  = sq[63:31];
    always_ff @(posedge clk) begin
      if (adv) begin
        k_s[j] <= k_s[j-1];
        m_s[j] <= t[32] ? t[32:1] : t[31:0];
        f_s[j] <= f_s[j-1] | ({29'd0, t[32]} << (NBITS - j));
      end
    end
  end

  assign y = {k_s[NBITS], f_s[NBITS]};

endmodule

`default_nettype wire

@@ rtl/core/gps_sqrt_pipe.sv @@
// ----------------------------------------------------------------------------
// gps_sqrt_pipe
// Floor square root of a 32-bit word, two result bits per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gps_sqrt_pipe
  import gps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        adv,
  input  wire logic [31:0] v,
  output logic      [15:0] root
);

  localparam int NST = 8;

  logic [17:0] rem_s [1:NST];
  logic [15:0] rt_s  [1:NST];
  logic [31:0] vr_s  [1:NST];

  // one restoring step: {remainder, root}
  function automatic logic [33:0] sq_step(input logic [17:0] r, input logic [15:0] q,
                                          input logic [1:0] d);
    logic [19:0] rr;
    logic [19:0] tr;
    logic [19:0] rn;
    logic [15:0] qn;
    rr = {r, d};
    tr = {2'b00, q, 2'b01};
    if (rr >= tr) begin
      rn = rr - tr;
      qn = {q[14:0], 1'b1};
    end else begin
      rn = rr;
      qn = {q[14:0], 1'b0};
    end
    return {rn[17:0], qn};
  endfunction

  for (genvar s = 1; s <= NST; s++) begin : g_st
    logic [17:0] pr;
    logic [15:0] pq;
    logic [31:0] pv;
    logic [33:0] a;
    logic [33:0] b;
    if (s == 1) begin : g_first
      assign pr = '0;
      assign pq = '0;
      assign pv = v;
    end else begin : g_next
      assign pr = rem_s[s-1];
      assign pq = rt_s[s-1];
      assign pv = vr_s[s-1];
    end
    assign a = sq_step(pr, pq, pv[31:30]);
    assign b = sq_step(a[33:16], a[15:0], pv[29:28]);
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_s[s] <= b[33:16];
        rt_s[s]  <= b[15:0];
        vr_s[s]  <= {pv[27:0], 4'd0};
      end
    end
  end

  assign root = rt_s[NST];

endmodule

`default_nettype wire

@@ rtl/core/gaussian_polar_sampler.sv @@
// ----------------------------------------------------------------------------
// gaussian_polar_sampler
// Marsaglia polar Gaussian sampler on a pipeline: one uniform pair in,
// up to two signed Q3.12 samples out.
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+--------------------------------------
//  input     | start && !busy       | uniform_a, uniform_b
//  result    | result_valid (1 cyc) | sample, second_of_pair, last
//  config    | cfg_we               | cfg_index, cfg_wdata
//
//  A pair may be accepted every cycle while busy is low. A pair that yields two
//  samples holds the whole pipeline while its second word waits in the pending
//  slot (busy high), so the next pair waits behind it. The depth is set by the
//  32-step divider (the log2 runs beside it), then one stage each for L and
//  c * L, the 8-stage square root, and the input, N and output registers.
//  rst is synchronous and clears the valid chain, the output stage and the
//  truncation registers. The receiver cannot stall; busy is the only backpressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gaussian_polar_sampler
  import gps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] uniform_a,
  input  wire logic [15:0] uniform_b,
  output logic             result_valid,
  output logic      [15:0] sample,
  output logic             second_of_pair,
  output logic             last,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [14:0] cfg_wdata
);

  // pipeline positions counted from the N stage (p0)
  localparam int DIV_STEPS = 32;
  localparam int P_END     = 42;   // last stage before the output register

  // ------------------------------------------------------------------ config
  logic        trunc_enable;
  logic [14:0] trunc_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      trunc_enable <= 1'b0;
      trunc_limit  <= TRUNC_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_TRUNC_ENABLE: trunc_enable <= cfg_wdata[0];
        REG_TRUNC_LIMIT:  trunc_limit  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // whole pipeline moves together; holds while a second word is pending
  logic    pend_v;
  logic    adv;
  assign adv  = !pend_v;
  assign busy = pend_v;

  // --------------------------------------------------- stage A: |a| squared
  // a = 2u - M is odd and never zero; it is negative exactly when the top bit of u is clear.
  logic [16:0] two_ua, two_ub;
  logic [15:0] mag_a, mag_b;
  assign two_ua = {uniform_a, 1'b0};
  assign two_ub = {uniform_b, 1'b0};
  assign mag_a  = uniform_a[15] ? 16'(two_ua - 17'(U_MAX)) : 16'(17'(U_MAX) - two_ua);
  assign mag_b  = uniform_b[15] ? 16'(two_ub - 17'(U_MAX)) : 16'(17'(U_MAX) - two_ub);

  logic        vld_a;
  logic        neg0_a, neg1_a;
  logic [31:0] sq0_a, sq1_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
    end else if (adv) begin
      vld_a <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg0_a <= !uniform_a[15];
      neg1_a <= !uniform_b[15];
      sq0_a  <= 32'(mag_a) * 32'(mag_a);
      sq1_a  <= 32'(mag_b) * 32'(mag_b);
    end
  end

  // ------------------------------------------- stage p0: N and the reject
  logic [32:0] n_sum;
  logic        keep_b;
  assign n_sum  = 33'(sq0_a) + 33'(sq1_a);
  assign keep_b = vld_a && (n_sum < M_SQ) && (n_sum != '0);

  logic        vld  [0:P_END];
  logic        neg0 [0:P_END];
  logic        neg1 [0:P_END];
  logic [31:0] n_b;
  logic [31:0] sq0_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= keep_b;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg0[0] <= neg0_a;
      neg1[0] <= neg1_a;
      n_b     <= n_sum[31:0];   // accepted N < M^2 fits 32 bits
      sq0_b   <= sq0_a;
    end
  end

  // valid and signs ride along
  for (genvar p = 1; p <= P_END; p++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[p] <= 1'b0;
      end else if (adv) begin
        vld[p] <= vld[p-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        neg0[p] <= neg0[p-1];
        neg1[p] <= neg1[p-1];
      end
    end
  end

  // ------------------------------------------- log2(N), p1..p31
  logic [34:0] ln_n;

  gps_log2_pipe u_log2 (
    .clk (clk),
    .adv (adv),
    .x   (n_b),
    .y   (ln_n)
  );

  // ------------------------------------------- c0 = (sq0 << 32) / N, p1..p32
  // sq0 < N, so the remainder stays under 32 bits and the quotient fits 32.
  logic [31:0] dv_rem [1:DIV_STEPS];
  logic [31:0] dv_q   [1:DIV_STEPS];
  logic [31:0] dv_n   [1:DIV_STEPS];

  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
    logic [31:0] pr, pq, pn;
    logic [32:0] t;
    logic        ge;
    if (j == 1) begin : g_first
      assign pr = sq0_b;
      assign pq = '0;
      assign pn = n_b;
    end else begin : g_next
      assign pr = dv_rem[j-1];
      assign pq = dv_q[j-1];
      assign pn = dv_n[j-1];
    end
    assign t  = {pr, 1'b0};
    assign ge = t >= {1'b0, pn};
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem[j] <= ge ? 32'(t - {1'b0, pn}) : t[31:0];
        dv_q[j]   <= {pq[30:0], ge};
        dv_n[j]   <= pn;
      end
    end
  end

  // ------------------------------------------- p32: d = 2 log2 M - log2 N
  logic [36:0] d_full;
  logic [29:0] dsh;
  assign d_full = {1'b0, LOG2_M, 1'b0} - {2'b00, ln_n};

  always_ff @(posedge clk) begin
    if (adv) begin
      dsh <= d_full[36] ? '0 : d_full[35:6];   // clamp when rounding goes negative
    end
  end

  // ------------------------------------------- p33: L = -2 ln S, c0, c1
  // c1 = 2^32 - c0 - (remainder != 0), since sq0 + sq1 = N.
  logic [60:0] l_prod;
  logic [30:0] l_q24;
  logic [31:0] c0, c1;
  logic [32:0] c1_full;
  assign l_prod  = 61'(dsh) * 61'(TWO_LN2_Q30);
  assign c1_full = 33'h1_0000_0000 - 33'(dv_q[DIV_STEPS])
                 - 33'(dv_rem[DIV_STEPS] != '0);

  always_ff @(posedge clk) begin
    if (adv) begin
      l_q24 <= l_prod[60:30];
      c0    <= dv_q[DIV_STEPS];
      c1    <= c1_full[31:0];
    end
  end

  // ------------------------------------------- p34: c * L, scaled
  logic [62:0] prod0, prod1;
  logic [30:0] v0, v1;
  assign prod0 = 63'(c0) * 63'(l_q24);
  assign prod1 = 63'(c1) * 63'(l_q24);

  always_ff @(posedge clk) begin
    if (adv) begin
      v0 <= prod0[PROD_SHIFT +: 31];
      v1 <= prod1[PROD_SHIFT +: 31];
    end
  end

  // ------------------------------------------- p35..p42: square roots
  logic [15:0] mag0, mag1;

  gps_sqrt_pipe u_sqrt0 (
    .clk  (clk),
    .adv  (adv),
    .v    ({1'b0, v0}),
    .root (mag0)
  );

  gps_sqrt_pipe u_sqrt1 (
    .clk  (clk),
    .adv  (adv),
    .v    ({1'b0, v1}),
    .root (mag1)
  );

  // ------------------------------------------- truncation, saturation
  function automatic logic [15:0] sat_sample(input logic neg, input logic [15:0] mag);
    logic [15:0] r;
    if (neg) begin
      r = (mag > 16'd32768) ? 16'h8000 : 16'(-mag);
    end else begin
      r = (mag > 16'd32767) ? 16'h7FFF : mag;
    end
    return r;
  endfunction

  logic    keep0, keep1;
  result_t r0, r1;
  assign keep0 = !(trunc_enable && (mag0 > {1'b0, trunc_limit}));
  assign keep1 = !(trunc_enable && (mag1 > {1'b0, trunc_limit}));

  always_comb begin
    r0.sample         = sat_sample(neg0[P_END], mag0);
    r0.second_of_pair = 1'b0;
    r0.last           = !keep1;
    r1.sample         = sat_sample(neg1[P_END], mag1);
    r1.second_of_pair = 1'b1;
    r1.last           = 1'b1;
  end

  // ------------------------------------------- output word and pending slot
  result_t out_r, pend_r;
  logic    out_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      pend_v <= 1'b0;
    end else if (pend_v) begin
      out_v  <= 1'b1;
      pend_v <= 1'b0;
    end else begin
      out_v  <= vld[P_END] && (keep0 || keep1);
      pend_v <= vld[P_END] && keep0 && keep1;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_v) begin
      out_r <= pend_r;
    end else begin
      out_r  <= keep0 ? r0 : r1;
      pend_r <= r1;
    end
  end

  assign result_valid   = out_v;
  assign sample         = out_r.sample;
  assign second_of_pair = out_r.second_of_pair;
  assign last           = out_r.last;

endmodule

`default_nettype wire

@@ rtl/core/gps_checker.sv @@
// ----------------------------------------------------------------------------
// gps_checker
// Port-level checks on the sampler's busy and result sequencing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "gaussian_polar_sampler_assert.svh"

module gps_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic busy,
  input wire logic result_valid,
  input wire logic second_of_pair,
  input wire logic last
);

  `GPS_ASSERT_NEXT(a_busy_one_cycle, busy, !busy, "busy held longer than one cycle")
  `GPS_ASSERT(a_busy_first_word, busy |-> (result_valid && !second_of_pair && !last), "busy without a leading first word")
  `GPS_ASSERT_NEXT(a_busy_then_second, busy, result_valid && second_of_pair && last, "second word missing after busy")
  `GPS_ASSERT(a_first_not_last_pairs, (result_valid && !last) |-> (!second_of_pair && busy), "non-last word without pending second")

endmodule

bind gaussian_polar_sampler gps_checker u_gps_checker (.*);

`default_nettype wire
